// ===== rtl/spr_pkg.sv =====
package spr_pkg;

  localparam int unsigned WIN_DEPTH = 9;
  localparam int unsigned FILL_W    = 4;

  typedef logic [7:0]        byte_t;
  typedef logic [FILL_W-1:0] count_t;

  // One emitted byte as it travels from the scanner to the output queue.
  typedef struct packed {
    byte_t data;
    logic  last;
  } spr_item_t;

  localparam byte_t CH_G     = 8'h67; // g
  localparam byte_t CH_L     = 8'h6C; // l
  localparam byte_t CH_US    = 8'h5F; // _
  localparam byte_t CH_P     = 8'h50; // P
  localparam byte_t CH_O     = 8'h6F; // o
  localparam byte_t CH_S_LC  = 8'h73; // s
  localparam byte_t CH_I     = 8'h69; // i
  localparam byte_t CH_N     = 8'h6E; // n
  localparam byte_t CH_T     = 8'h74; // t
  localparam byte_t CH_S_UC  = 8'h53; // S
  localparam byte_t CH_C     = 8'h43; // C
  localparam byte_t CH_F     = 8'h46; // F
  localparam byte_t CH_R     = 8'h72; // r
  localparam byte_t CH_A     = 8'h61; // a
  localparam byte_t CH_D     = 8'h44; // D
  localparam byte_t CH_HASH  = 8'h23; // #
  localparam byte_t CH_V     = 8'h76; // v
  localparam byte_t CH_E     = 8'h65; // e
  localparam byte_t CH_TWO   = 8'h32; // 2
  localparam byte_t CH_SLASH = 8'h2F; // /

  localparam count_t SKIP_POS   = 4'd5;
  localparam count_t SKIP_POINT = 4'd8;
  localparam count_t SKIP_SHORT = 4'd3;

endpackage

// ===== rtl/shader_identifier_prefix_rewriter.sv =====
// channel  | handshake    | payload             | accepted when
// ---------+--------------+---------------------+------------------
// input    | push / full  | data_byte, last     | push && !full
// result   | empty / pop  | out_byte, out_last  | pop && !empty
//
// Queue not full: one byte in, one byte out per cycle once the nine-byte window is full.
// A byte with last set flushes the final min(n, 9) bytes of an n-byte packet, one byte
// per cycle from the window into the queue while it has room; full stays high meanwhile.
// full also rises while the output queue (QUEUE_DEPTH entries) is full.
// Synchronous active-high reset empties the window and the queue.
module shader_identifier_prefix_rewriter #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  spr_pkg::byte_t data_byte,
  input  logic           last,
  output logic           empty,
  input  logic           pop,
  output spr_pkg::byte_t out_byte,
  output logic           out_last
);
  import spr_pkg::*;

  logic      q_full;
  logic      q_push;
  spr_item_t q_item;

  spr_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last      (last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  spr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_item  (q_item),
    .q_full   (q_full),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

// ===== rtl/spr_scan.sv =====
module spr_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  spr_pkg::byte_t    data_byte,
  input  logic              last,
  input  logic              q_full,
  output logic              q_push,
  output spr_pkg::spr_item_t q_item
);
  import spr_pkg::*;

  byte_t  window [WIN_DEPTH];
  count_t fill;
  count_t skip;
  logic   flushing;

  byte_t  w_cur [WIN_DEPTH];
  byte_t  shifted [WIN_DEPTH];
  logic   vld [WIN_DEPTH];
  count_t f_cur;
  count_t skip_next;
  logic   mod0;
  logic   mod1;
  byte_t  mod1_char;
  logic   accept;
  logic   emit;
  logic   gl, pos, point, fra, dd, ver;

  assign full   = flushing || q_full;
  assign accept = push && !full;
  assign emit   = flushing ? !q_full : (accept && !last && fill == count_t'(WIN_DEPTH - 1));

  // Window as seen this cycle: unless flushing, the incoming byte lands at the fill position.
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w_cur[i] = (!flushing && count_t'(i) == fill) ? data_byte : window[i];
    end
    f_cur = flushing ? fill : fill + count_t'(1);
    for (int i = 0; i < WIN_DEPTH; i++) begin
      vld[i] = count_t'(i) < f_cur;
    end
  end

  always_comb begin
    gl    = vld[0] && w_cur[0] == CH_G && vld[1] && w_cur[1] == CH_L
            && vld[2] && w_cur[2] == CH_US;
    pos   = vld[3] && w_cur[3] == CH_P && vld[4] && w_cur[4] == CH_O
            && vld[5] && w_cur[5] == CH_S_LC;
    point = vld[3] && w_cur[3] == CH_P && vld[4] && w_cur[4] == CH_O
            && vld[5] && w_cur[5] == CH_I && vld[6] && w_cur[6] == CH_N
            && vld[7] && w_cur[7] == CH_T
            && vld[8] && (w_cur[8] == CH_S_UC || w_cur[8] == CH_C);
    fra   = vld[3] && w_cur[3] == CH_F && vld[4] && w_cur[4] == CH_R
            && vld[5] && w_cur[5] == CH_A;
    dd    = vld[3] && w_cur[3] == CH_D;
    ver   = vld[0] && w_cur[0] == CH_HASH && vld[1] && w_cur[1] == CH_V
            && vld[2] && w_cur[2] == CH_E && vld[3] && w_cur[3] == CH_R;

    mod0      = 1'b0;
    mod1      = 1'b0;
    mod1_char = CH_TWO;
    skip_next = '0;
    priority if (skip != '0) begin
      skip_next = skip - count_t'(1);
    end else if (gl) begin
      priority if (pos) begin
        skip_next = SKIP_POS;
      end else if (point) begin
        skip_next = SKIP_POINT;
      end else if (fra || dd) begin
        skip_next = SKIP_SHORT;
      end else begin
        mod1      = 1'b1;
        skip_next = SKIP_SHORT;
      end
    end else if (ver) begin
      mod0      = 1'b1;
      mod1      = 1'b1;
      mod1_char = CH_SLASH;
      skip_next = SKIP_SHORT;
    end else begin
      skip_next = '0;
    end

    for (int k = 0; k < WIN_DEPTH - 1; k++) begin
      shifted[k] = w_cur[k+1];
    end
    shifted[WIN_DEPTH-1] = w_cur[WIN_DEPTH-1];
    if (mod1) begin
      shifted[0] = mod1_char;
    end
  end

  assign q_push      = emit;
  assign q_item.data = mod0 ? CH_SLASH : w_cur[0];
  assign q_item.last = flushing && fill == count_t'(1);

  always_ff @(posedge clk) begin
    if (emit) begin
      window <= shifted;
    end else if (accept) begin
      window <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      skip     <= '0;
      flushing <= 1'b0;
    end else if (flushing) begin
      if (emit) begin
        if (fill == count_t'(1)) begin
          // packet done: nothing carries into the next one
          fill     <= '0;
          skip     <= '0;
          flushing <= 1'b0;
        end else begin
          fill <= fill - count_t'(1);
          skip <= skip_next;
        end
      end
    end else if (accept) begin
      if (last) begin
        fill     <= fill + count_t'(1);
        flushing <= 1'b1;
      end else if (emit) begin
        skip <= skip_next;
      end else begin
        fill <= fill + count_t'(1);
      end
    end
  end

endmodule

// ===== rtl/spr_fifo.sv =====
module spr_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  spr_pkg::spr_item_t wr_item,
  output logic               q_full,
  output logic               empty,
  input  logic               pop,
  output spr_pkg::byte_t     out_byte,
  output logic               out_last
);
  import spr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  spr_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign q_full   = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = pop && !empty;
  assign out_byte = mem[rd_ptr].data;
  assign out_last = mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
